// File: src/s2b_pkg.sv
package s2b_pkg;

    // default parameter values
    localparam int OFFSET_BITS_DEF = 32;
    localparam int MAX_BLOCK_DEF   = 16;

    // field and register widths
    localparam int BATCH_W  = 16;
    localparam int ROW_W    = 10;
    localparam int COL_W    = 10;
    localparam int NB_W     = 9;
    localparam int DIM_W    = 11;
    localparam int DEPTH_W  = 13;
    localparam int BREG_W   = 5;
    localparam int PAD_W    = 8;
    localparam int OUT_OFF_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;
    localparam int IN_DATA_W = 40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IN_BATCH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_DEPTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP_ROWS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT_COLS = 3'd7;

    // tensor geometry with zero dimensions already forced to one
    typedef struct packed {
        logic [DIM_W-1:0]   height;
        logic [DIM_W-1:0]   width;
        logic [DEPTH_W-1:0] depth;
        logic [PAD_W-1:0]   pad_top;
        logic [PAD_W-1:0]   left_cols;
    } geom_t;

endpackage

// File: src/s2b_div.sv
module s2b_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 9,
    parameter int PAY_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [PAY_W-1:0] in_pay,
    input  logic [DEN_W-1:0] den,
    output logic             out_valid,
    output logic [NUM_W-1:0] out_quot,
    output logic [DEN_W-1:0] out_rem,
    output logic [PAY_W-1:0] out_pay
);

    // one quotient bit per stage, dividend shifts out at the top while
    // quotient bits shift in at the bottom
    logic             valid_reg [NUM_W];
    logic [DEN_W-1:0] rem_reg   [NUM_W];
    logic [NUM_W-1:0] work_reg  [NUM_W];
    logic [PAY_W-1:0] pay_reg   [NUM_W];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic             src_valid;
        logic [DEN_W-1:0] src_rem;
        logic [NUM_W-1:0] src_work;
        logic [PAY_W-1:0] src_pay;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             fits;

        if (k == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src_rem   = '0;
            assign src_work  = in_num;
            assign src_pay   = in_pay;
        end
        else
        begin : g_next
            assign src_valid = valid_reg[k-1];
            assign src_rem   = rem_reg[k-1];
            assign src_work  = work_reg[k-1];
            assign src_pay   = pay_reg[k-1];
        end

        // trial subtract of the divisor from the shifted remainder
        assign trial = {src_rem, src_work[NUM_W-1]};
        assign diff  = trial - {1'b0, den};
        assign fits  = (trial >= {1'b0, den});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                work_reg[k] <= {src_work[NUM_W-2:0], fits};
                pay_reg[k]  <= src_pay;
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_quot  = work_reg[NUM_W-1];
    assign out_rem   = rem_reg[NUM_W-1];
    assign out_pay   = pay_reg[NUM_W-1];

endmodule

// File: src/s2b_addr.sv
module s2b_addr #(
    parameter int OFFSET_BITS = s2b_pkg::OFFSET_BITS_DEF,
    parameter int MAX_BLOCK   = s2b_pkg::MAX_BLOCK_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  s2b_pkg::geom_t                       geom,
    input  logic [$clog2(MAX_BLOCK+1)-1:0]       block_w,
    input  logic [$clog2(MAX_BLOCK+1)-1:0]       block_h,
    input  logic                                 in_valid,
    input  logic [s2b_pkg::NB_W-1:0]             src_batch,
    input  logic [s2b_pkg::ROW_W-1:0]            out_row,
    input  logic [s2b_pkg::COL_W-1:0]            out_col,
    input  logic [s2b_pkg::BATCH_W-1:0]          shift_h,
    input  logic [$clog2(MAX_BLOCK+1)-1:0]       shift_w,
    output logic                                 out_valid,
    output logic                                 out_pad,
    output logic [s2b_pkg::OUT_OFF_W-1:0]        out_offset
);

    localparam int BLK_W  = $clog2(MAX_BLOCK+1);
    localparam int RB_W   = s2b_pkg::ROW_W + BLK_W;
    localparam int Y_W    = ((RB_W > s2b_pkg::BATCH_W) ? RB_W : s2b_pkg::BATCH_W) + 1;
    localparam int X_W    = s2b_pkg::COL_W + BLK_W;
    localparam int DIM_W  = s2b_pkg::DIM_W;
    localparam int NB_W   = s2b_pkg::NB_W;
    localparam int T1_W   = NB_W + DIM_W + 1;
    localparam int T2_W   = T1_W + DIM_W + 1;
    localparam int KEEP_W = (OFFSET_BITS < s2b_pkg::OUT_OFF_W) ? OFFSET_BITS
                                                                : s2b_pkg::OUT_OFF_W;

    // stage a: padded source coordinates
    logic            a_valid_reg;
    logic [Y_W-1:0]  a_y_reg;
    logic [X_W-1:0]  a_x_reg;
    logic [NB_W-1:0] a_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_y_reg <= Y_W'(out_row) * Y_W'(block_h) + Y_W'(shift_h);
            a_x_reg <= X_W'(out_col) * X_W'(block_w) + X_W'(shift_w);
            a_b_reg <= src_batch;
        end
    end

    // stage b: padding test and unpadded coordinates
    logic             b_valid_reg;
    logic             b_pad_reg;
    logic [DIM_W-1:0] b_sy_reg;
    logic [DIM_W-1:0] b_sx_reg;
    logic [NB_W-1:0]  b_b_reg;
    logic             b_pad_next;
    logic [Y_W-1:0]   b_sy_full;
    logic [X_W:0]     b_sx_full;

    always_comb
    begin
        b_pad_next = (a_y_reg < Y_W'(geom.pad_top))
                  || (a_y_reg >= Y_W'(geom.pad_top) + Y_W'(geom.height))
                  || ((X_W+1)'(a_x_reg) < (X_W+1)'(geom.left_cols))
                  || ((X_W+1)'(a_x_reg) >= (X_W+1)'(geom.left_cols) + (X_W+1)'(geom.width));
        b_sy_full  = a_y_reg - Y_W'(geom.pad_top);
        b_sx_full  = (X_W+1)'(a_x_reg) - (X_W+1)'(geom.left_cols);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_pad_reg <= b_pad_next;
            b_sy_reg  <= b_sy_full[DIM_W-1:0];
            b_sx_reg  <= b_sx_full[DIM_W-1:0];
            b_b_reg   <= a_b_reg;
        end
    end

    // stage c: row index into the tensor
    logic             c_valid_reg;
    logic             c_pad_reg;
    logic [T1_W-1:0]  c_t1_reg;
    logic [DIM_W-1:0] c_sx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_pad_reg <= b_pad_reg;
            c_t1_reg  <= T1_W'(b_b_reg) * T1_W'(geom.height) + T1_W'(b_sy_reg);
            c_sx_reg  <= b_sx_reg;
        end
    end

    // stage d: spatial position index, only the kept offset bits matter
    logic              d_valid_reg;
    logic              d_pad_reg;
    logic [KEEP_W-1:0] d_t2_reg;
    logic [T2_W-1:0]   d_t2_full;

    assign d_t2_full = T2_W'(c_t1_reg) * T2_W'(geom.width) + T2_W'(c_sx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (en)
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_pad_reg <= c_pad_reg;
            d_t2_reg  <= d_t2_full[KEEP_W-1:0];
        end
    end

    // stage e: scale by channel depth, zero for padding
    logic              e_valid_reg;
    logic              e_pad_reg;
    logic [KEEP_W-1:0] e_off_reg;
    logic [KEEP_W-1:0] e_off_next;

    assign e_off_next = d_pad_reg ? '0 : d_t2_reg * KEEP_W'(geom.depth);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else if (en)
            e_valid_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_pad_reg <= d_pad_reg;
            e_off_reg <= e_off_next;
        end
    end

    assign out_valid  = e_valid_reg;
    assign out_pad    = e_pad_reg;
    assign out_offset = s2b_pkg::OUT_OFF_W'(e_off_reg);

endmodule

// File: src/space_to_batch_address_gen.sv
// Space-to-batch address generator for NHWC tensors. Each request on the
// slave stream is one output position (batch, row, column); each request on
// the master stream says whether that position is zero padding (tuser high)
// or gives the element offset of the first of channel_depth source elements
// (tdata). One position is accepted per clock while the skid entry is empty.
// Requests pass two 16-stage divider pipelines (one quotient bit per stage,
// for the batch split and the block shift), five address stages and the
// output register with a one-entry skid, so the slave side keeps taking
// requests while one result waits. Configuration must be written through
// cfg_we/cfg_addr/cfg_data only while nothing is in flight (unenforced here);
// zero dimensions and blocks are used as one, blocks saturate to MAX_BLOCK.
module space_to_batch_address_gen #(
    parameter int OFFSET_BITS = s2b_pkg::OFFSET_BITS_DEF,
    parameter int MAX_BLOCK   = s2b_pkg::MAX_BLOCK_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [s2b_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [s2b_pkg::CFG_DATA_W-1:0]    cfg_data,
    // output positions
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [s2b_pkg::IN_DATA_W-1:0]     s_tdata,   // out_batch, out_row, out_col
    // source addresses
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [s2b_pkg::OUT_OFF_W-1:0]     m_tdata,   // source_offset
    output logic                              m_tuser    // is_padding
);

    localparam int BLK_W   = $clog2(MAX_BLOCK+1);
    localparam int BATCH_W = s2b_pkg::BATCH_W;
    localparam int ROW_W   = s2b_pkg::ROW_W;
    localparam int COL_W   = s2b_pkg::COL_W;
    localparam int NB_W    = s2b_pkg::NB_W;
    localparam int DIM_W   = s2b_pkg::DIM_W;
    localparam int DEPTH_W = s2b_pkg::DEPTH_W;
    localparam int BREG_W  = s2b_pkg::BREG_W;
    localparam int PAD_W   = s2b_pkg::PAD_W;
    localparam int OFF_W   = s2b_pkg::OUT_OFF_W;
    localparam int POS_W   = ROW_W + COL_W;
    localparam int PAY2_W  = NB_W + POS_W;

    // zero forced to one, then capped at the largest supported block
    function automatic logic [BLK_W-1:0] block_limit(input logic [BREG_W-1:0] v);
        logic [BREG_W-1:0] nz;
        nz = (v == '0) ? BREG_W'(1) : v;
        if (32'(nz) > 32'(MAX_BLOCK))
            return BLK_W'(MAX_BLOCK);
        return BLK_W'(nz);
    endfunction

    // configuration registers, held as the values actually used
    logic [NB_W-1:0]    nb_reg;
    logic [DIM_W-1:0]   h_reg;
    logic [DIM_W-1:0]   w_reg;
    logic [DEPTH_W-1:0] d_reg;
    logic [BLK_W-1:0]   bw_reg;
    logic [BLK_W-1:0]   bh_reg;
    logic [PAD_W-1:0]   pt_reg;
    logic [PAD_W-1:0]   pl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_reg <= NB_W'(1);
            h_reg  <= DIM_W'(1);
            w_reg  <= DIM_W'(1);
            d_reg  <= DEPTH_W'(1);
            bw_reg <= BLK_W'(1);
            bh_reg <= BLK_W'(1);
            pt_reg <= '0;
            pl_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                s2b_pkg::REG_IN_BATCH:
                    nb_reg <= (cfg_data[NB_W-1:0] == '0) ? NB_W'(1) : cfg_data[NB_W-1:0];
                s2b_pkg::REG_IN_HEIGHT:
                    h_reg <= (cfg_data[DIM_W-1:0] == '0) ? DIM_W'(1) : cfg_data[DIM_W-1:0];
                s2b_pkg::REG_IN_WIDTH:
                    w_reg <= (cfg_data[DIM_W-1:0] == '0) ? DIM_W'(1) : cfg_data[DIM_W-1:0];
                s2b_pkg::REG_CHANNEL_DEPTH:
                    d_reg <= (cfg_data[DEPTH_W-1:0] == '0) ? DEPTH_W'(1)
                                                           : cfg_data[DEPTH_W-1:0];
                s2b_pkg::REG_BLOCK_WIDTH:
                    bw_reg <= block_limit(cfg_data[BREG_W-1:0]);
                s2b_pkg::REG_BLOCK_HEIGHT:
                    bh_reg <= block_limit(cfg_data[BREG_W-1:0]);
                s2b_pkg::REG_PAD_TOP_ROWS:
                    pt_reg <= cfg_data[PAD_W-1:0];
                s2b_pkg::REG_PAD_LEFT_COLS:
                    pl_reg <= cfg_data[PAD_W-1:0];
                default:
                    ;
            endcase
        end
    end

    s2b_pkg::geom_t geom;

    assign geom.height    = h_reg;
    assign geom.width     = w_reg;
    assign geom.depth     = d_reg;
    assign geom.pad_top   = pt_reg;
    assign geom.left_cols = pl_reg;

    // the whole pipeline moves unless the skid entry is occupied
    logic skid_valid_reg;
    logic pipe_en;

    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    // unpack the request
    logic [BATCH_W-1:0] in_batch_f;
    logic [ROW_W-1:0]   in_row_f;
    logic [COL_W-1:0]   in_col_f;

    assign in_batch_f = s_tdata[BATCH_W-1:0];
    assign in_row_f   = s_tdata[BATCH_W+ROW_W-1:BATCH_W];
    assign in_col_f   = s_tdata[BATCH_W+ROW_W+COL_W-1:BATCH_W+ROW_W];

    // out_batch split into source batch and block index
    logic               div1_valid;
    logic [BATCH_W-1:0] div1_quot;
    logic [NB_W-1:0]    div1_rem;
    logic [POS_W-1:0]   div1_pay;

    s2b_div #(
        .NUM_W (BATCH_W),
        .DEN_W (NB_W),
        .PAY_W (POS_W)
    ) u_div_batch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .in_num    (in_batch_f),
        .in_pay    ({in_row_f, in_col_f}),
        .den       (nb_reg),
        .out_valid (div1_valid),
        .out_quot  (div1_quot),
        .out_rem   (div1_rem),
        .out_pay   (div1_pay)
    );

    // block index split into row and column shift
    logic               div2_valid;
    logic [BATCH_W-1:0] div2_quot;
    logic [BLK_W-1:0]   div2_rem;
    logic [PAY2_W-1:0]  div2_pay;

    s2b_div #(
        .NUM_W (BATCH_W),
        .DEN_W (BLK_W),
        .PAY_W (PAY2_W)
    ) u_div_block (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (div1_valid),
        .in_num    (div1_quot),
        .in_pay    ({div1_rem, div1_pay}),
        .den       (bw_reg),
        .out_valid (div2_valid),
        .out_quot  (div2_quot),
        .out_rem   (div2_rem),
        .out_pay   (div2_pay)
    );

    // address arithmetic
    logic             addr_valid;
    logic             addr_pad;
    logic [OFF_W-1:0] addr_offset;

    s2b_addr #(
        .OFFSET_BITS (OFFSET_BITS),
        .MAX_BLOCK   (MAX_BLOCK)
    ) u_addr (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (pipe_en),
        .geom       (geom),
        .block_w    (bw_reg),
        .block_h    (bh_reg),
        .in_valid   (div2_valid),
        .src_batch  (div2_pay[PAY2_W-1:POS_W]),
        .out_row    (div2_pay[POS_W-1:COL_W]),
        .out_col    (div2_pay[COL_W-1:0]),
        .shift_h    (div2_quot),
        .shift_w    (div2_rem),
        .out_valid  (addr_valid),
        .out_pad    (addr_pad),
        .out_offset (addr_offset)
    );

    // output register with one skid entry
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_pad_reg;
    logic             out_pad_next;
    logic [OFF_W-1:0] out_off_reg;
    logic [OFF_W-1:0] out_off_next;
    logic             skid_valid_next;
    logic             skid_pad_reg;
    logic             skid_pad_next;
    logic [OFF_W-1:0] skid_off_reg;
    logic [OFF_W-1:0] skid_off_next;
    logic             out_take;

    assign out_take = out_valid_reg && m_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_pad_next    = out_pad_reg;
        out_off_next    = out_off_reg;
        skid_valid_next = skid_valid_reg;
        skid_pad_next   = skid_pad_reg;
        skid_off_next   = skid_off_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_valid_next  = 1'b1;
                out_pad_next    = skid_pad_reg;
                out_off_next    = skid_off_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            out_valid_next = addr_valid;
            out_pad_next   = addr_pad;
            out_off_next   = addr_offset;
        end
        else if (addr_valid)
        begin
            skid_valid_next = 1'b1;
            skid_pad_next   = addr_pad;
            skid_off_next   = addr_offset;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pad_reg  <= out_pad_next;
        out_off_reg  <= out_off_next;
        skid_pad_reg <= skid_pad_next;
        skid_off_reg <= skid_off_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_off_reg;
    assign m_tuser  = out_pad_reg;

endmodule
